FILE: src/scbm_pkg.sv
// Shared types, constants and ring helper functions for the swap chain buffer manager.
package scbm_pkg;

   // Sizes of the ring and of the fields.
   localparam int MAX_NODES  = 8;
   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int COUNT_W    = 4;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int BYTES_W    = 16;
   localparam int ADDR_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = NODE_W + BYTES_W;

   // Register map of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_BASE  = 2'd2;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 4'd3;

   // Request kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE_BORROW,
      KIND_WRITE_RETURN,
      KIND_READ_BORROW,
      KIND_READ_RETURN
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED,
      STATUS_EMPTY,
      STATUS_RETURNED,
      STATUS_REJECTED
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_REBUILD,
      ST_IDLE,
      ST_LINK,
      ST_FETCH,
      ST_SPLICE,
      ST_DONE
   } state_type;

   // One write into a link memory.
   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      logic [NODE_W-1:0] data;
   } link_write_type;

   // Finished result handed from the sequencer to the output stage.
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [NODE_W-1:0] node;
   } result_type;

   // Clamp the programmed node count to the usable range.
   function automatic logic [COUNT_W-1:0] live_count(input logic [COUNT_W-1:0] n);
      if (n == '0) begin
         return COUNT_W'(1);
      end
      if (n > COUNT_W'(MAX_NODES)) begin
         return COUNT_W'(MAX_NODES);
      end
      return n;
   endfunction

   // Successor of entry i in a freshly built ring of n nodes.
   function automatic logic [NODE_W-1:0] ring_next(input logic [NODE_W-1:0] i,
                                                   input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] up;
      up = COUNT_W'(i) + COUNT_W'(1);
      if (COUNT_W'(i) >= n || up == n) begin
         return '0;
      end
      return NODE_W'(up);
   endfunction

   // Predecessor of entry i in a freshly built ring of n nodes.
   function automatic logic [NODE_W-1:0] ring_prev(input logic [NODE_W-1:0] i,
                                                   input logic [COUNT_W-1:0] n);
      if (COUNT_W'(i) >= n) begin
         return '0;
      end
      if (i == '0) begin
         return NODE_W'(n - COUNT_W'(1));
      end
      return i - NODE_W'(1);
   endfunction

endpackage

FILE: src/scbm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module scbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; a read of the entry being written returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/scbm_seq.sv
// Sequencer that walks the linked ring in the link memories for each request beat.
module scbm_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  scbm_pkg::kind_type               req_kind,
   input  logic [scbm_pkg::NODE_W-1:0]      req_node_index,
   input  logic                             csr_we,
   input  logic [scbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scbm_pkg::COUNT_W-1:0]     csr_count,
   input  logic [scbm_pkg::NODE_W-1:0]      next_rd,
   input  logic [scbm_pkg::NODE_W-1:0]      prev_rd,
   output logic [scbm_pkg::NODE_W-1:0]      link_rd_addr,
   output scbm_pkg::link_write_type         next_wr,
   output scbm_pkg::link_write_type         prev_wr,
   input  logic                             slot_free,
   output scbm_pkg::result_type             result
);
   import scbm_pkg::*;

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    sweep_ff, sweep_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [NODE_W-1:0]    cursor_ff, cursor_in;
   logic [MAX_NODES-1:0] loan_ff, loan_in;
   kind_type             kind_ff, kind_in;
   logic [NODE_W-1:0]    idx_ff, idx_in;
   logic [NODE_W-1:0]    held_ff, held_in;
   status_type           res_status_ff, res_status_in;
   logic [NODE_W-1:0]    res_node_ff, res_node_in;

   logic [COUNT_W-1:0] live;
   logic               accept;
   logic               count_write;
   logic               is_borrow;
   logic               ring_single;
   logic               return_ok;

   // Decoded conditions.
   assign live        = live_count(count_ff);
   assign accept      = req_valid && !req_stall;
   assign count_write = csr_we && (csr_index == REG_NODE_COUNT);
   assign is_borrow   = (kind_ff == KIND_WRITE_BORROW) || (kind_ff == KIND_READ_BORROW);
   assign ring_single = (next_rd == cursor_ff);
   assign return_ok   = (COUNT_W'(idx_ff) < live) && loan_ff[idx_ff];

   // Input is taken when idle, or when the finished result moves to the output stage.
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_DONE) && slot_free));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_REBUILD: begin
            if (sweep_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            if (is_borrow) begin
               if (ring_single || (kind_ff == KIND_READ_BORROW)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FETCH;
               end
            end else if (return_ok) begin
               state_in = ST_SPLICE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FETCH: begin
            state_in = ST_DONE;
         end
         ST_SPLICE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = accept ? ST_LINK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (count_write) begin
         state_in = ST_REBUILD;
      end
   end

   // Memory accesses and datapath register updates for each state.
   always_comb begin
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      loan_in       = loan_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      held_in       = held_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      link_rd_addr  = cursor_ff;
      next_wr       = '0;
      prev_wr       = '0;

      case (state_ff)
         // Write one entry of the fresh ring per cycle.
         ST_REBUILD: begin
            next_wr  = '{en: 1'b1, addr: sweep_ff, data: ring_next(sweep_ff, live)};
            prev_wr  = '{en: 1'b1, addr: sweep_ff, data: ring_prev(sweep_ff, live)};
            sweep_in = sweep_ff + NODE_W'(1);
         end
         // Links of the cursor node are on the read data.
         ST_LINK: begin
            link_rd_addr = next_rd;
            if (is_borrow) begin
               if (ring_single) begin
                  res_status_in = STATUS_EMPTY;
                  res_node_in   = '0;
               end else if (kind_ff == KIND_READ_BORROW) begin
                  // Unlink the cursor node and step the cursor to its successor.
                  next_wr            = '{en: 1'b1, addr: prev_rd, data: next_rd};
                  prev_wr            = '{en: 1'b1, addr: next_rd, data: prev_rd};
                  cursor_in          = next_rd;
                  loan_in[cursor_ff] = 1'b1;
                  res_status_in      = STATUS_GRANTED;
                  res_node_in        = cursor_ff;
               end else begin
                  // Fetch the links of the node after the cursor.
                  held_in = next_rd;
               end
            end else if (return_ok) begin
               // First half of the insertion after the cursor.
               next_wr = '{en: 1'b1, addr: cursor_ff, data: idx_ff};
               prev_wr = '{en: 1'b1, addr: idx_ff, data: cursor_ff};
               held_in = next_rd;
            end else begin
               res_status_in = STATUS_REJECTED;
               res_node_in   = idx_ff;
            end
         end
         // Unlink the node after the cursor.
         ST_FETCH: begin
            next_wr          = '{en: 1'b1, addr: prev_rd, data: next_rd};
            prev_wr          = '{en: 1'b1, addr: next_rd, data: prev_rd};
            loan_in[held_ff] = 1'b1;
            res_status_in    = STATUS_GRANTED;
            res_node_in      = held_ff;
         end
         // Second half of the insertion; a write return also moves the cursor.
         ST_SPLICE: begin
            next_wr         = '{en: 1'b1, addr: idx_ff, data: held_ff};
            prev_wr         = '{en: 1'b1, addr: held_ff, data: idx_ff};
            loan_in[idx_ff] = 1'b0;
            if (kind_ff == KIND_WRITE_RETURN) begin
               cursor_in = idx_ff;
            end
            res_status_in = STATUS_RETURNED;
            res_node_in   = idx_ff;
         end
         default: begin
         end
      endcase

      // Capture a new request; the read of the cursor links starts here.
      if (accept) begin
         kind_in = req_kind;
         idx_in  = req_node_index;
      end

      // A node count write rebuilds the ring from scratch.
      if (count_write) begin
         count_in  = csr_count;
         sweep_in  = '0;
         cursor_in = '0;
         loan_in   = '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_REBUILD;
         sweep_ff  <= '0;
         count_ff  <= NODE_COUNT_RESET;
         cursor_ff <= '0;
         loan_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         loan_ff   <= loan_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      held_ff       <= held_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
   end

   assign result = '{valid: (state_ff == ST_DONE), status: res_status_ff, node: res_node_ff};

endmodule

FILE: src/scbm_out.sv
// Output stage: buffer address calculation, address registers and the result register.
module scbm_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [scbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scbm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  scbm_pkg::result_type              result,
   output logic                              slot_free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [scbm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [scbm_pkg::NODE_W-1:0]       rsp_granted_node,
   output logic [scbm_pkg::ADDR_W-1:0]       rsp_buffer_address
);
   import scbm_pkg::*;

   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic                valid_ff, valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [NODE_W-1:0]   node_ff;
   logic [ADDR_W-1:0]   addr_ff;

   logic [PROD_W-1:0] offset;
   logic [ADDR_W-1:0] addr_in;
   logic              has_addr;
   logic              load;

   // Address registers.
   always_comb begin
      bytes_in = bytes_ff;
      base_in  = base_ff;
      if (csr_we && (csr_index == REG_BUFFER_BYTES)) begin
         bytes_in = csr_wdata[BYTES_W-1:0];
      end
      if (csr_we && (csr_index == REG_BUFFER_BASE)) begin
         base_in = csr_wdata[ADDR_W-1:0];
      end
   end

   // Buffer address of the node; only grants and accepted returns report one.
   assign offset   = PROD_W'(result.node) * PROD_W'(bytes_ff);
   assign has_addr = (result.status == STATUS_GRANTED) || (result.status == STATUS_RETURNED);
   assign addr_in  = has_addr ? (base_ff + ADDR_W'(offset)) : '0;

   // The result register takes a new beat when empty or when its beat leaves.
   assign slot_free = !valid_ff || !rsp_stall;
   assign load      = result.valid && slot_free;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
         base_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         bytes_ff <= bytes_in;
         base_ff  <= base_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= result.status;
         node_ff   <= result.node;
         addr_ff   <= addr_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_node   = node_ff;
   assign rsp_buffer_address = addr_ff;

endmodule

FILE: src/swap_chain_buffer_manager_core.sv
// Top level of the swap chain buffer manager: link memories, sequencer and output stage.
//
//   Channel  Direction  Handshake            Beat contents
//   req      in         req_valid/req_stall  req_kind, req_node_index
//   rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_granted_node, rsp_buffer_address
//   csr      in         csr_we               csr_index, csr_wdata
//
// A read borrow, a failed borrow or a rejected return goes from acceptance through the
// link state to done; a write borrow or an accepted return also passes the fetch or
// splice state, since each link memory has one read and one write port and the ring
// update needs a second access. Reset and every node_count write start a pass that
// rebuilds the ring, one entry per cycle, with req_stall high. A stalled result waits
// in the output register while the next request beat is taken and worked on.
module swap_chain_buffer_manager_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [scbm_pkg::KIND_W-1:0]       req_kind,
   input  logic [scbm_pkg::NODE_W-1:0]       req_node_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [scbm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [scbm_pkg::NODE_W-1:0]       rsp_granted_node,
   output logic [scbm_pkg::ADDR_W-1:0]       rsp_buffer_address,
   input  logic                              csr_we,
   input  logic [scbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import scbm_pkg::*;

   logic [NODE_W-1:0] next_rd;
   logic [NODE_W-1:0] prev_rd;
   logic [NODE_W-1:0] link_rd_addr;
   link_write_type    next_wr;
   link_write_type    prev_wr;
   result_type        result;
   logic              slot_free;

   // Successor links of the ring.
   scbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr.en),
      .wr_addr (next_wr.addr),
      .wr_data (next_wr.data),
      .rd_addr (link_rd_addr),
      .rd_data (next_rd)
   );

   // Predecessor links of the ring.
   scbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr.en),
      .wr_addr (prev_wr.addr),
      .wr_data (prev_wr.data),
      .rd_addr (link_rd_addr),
      .rd_data (prev_rd)
   );

   // Ring walk and update.
   scbm_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (kind_type'(req_kind)),
      .req_node_index (req_node_index),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_count      (csr_wdata[COUNT_W-1:0]),
      .next_rd        (next_rd),
      .prev_rd        (prev_rd),
      .link_rd_addr   (link_rd_addr),
      .next_wr        (next_wr),
      .prev_wr        (prev_wr),
      .slot_free      (slot_free),
      .result         (result)
   );

   // Address calculation and result register.
   scbm_out u_out (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .result             (result),
      .slot_free          (slot_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_node   (rsp_granted_node),
      .rsp_buffer_address (rsp_buffer_address)
   );

   // A node count write starts the rebuild pass, which holds off new requests.
   a_rebuild_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == REG_NODE_COUNT) |=> req_stall)
      else $error("request taken during ring rebuild");

   // A finished result that cannot move to the output register is kept.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      result.valid && !slot_free && !csr_we |=> result.valid)
      else $error("finished result dropped while output register was full");

   // A failed borrow reports neither a node nor an address.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |->
         (rsp_granted_node == '0) && (rsp_buffer_address == '0))
      else $error("failed borrow reports a node or an address");

   // A rejected return reports no address.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REJECTED) |-> (rsp_buffer_address == '0))
      else $error("rejected return reports an address");

endmodule

FILE: tb/swap_chain_buffer_manager_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the swap chain buffer manager core with a ring predictor.
module swap_chain_buffer_manager_core_test;
   import scbm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_BEATS = 103;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   // One predicted result beat.
   typedef struct {
      status_type        status;
      logic [NODE_W-1:0] node;
      logic [ADDR_W-1:0] address;
   } pool_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind;
   logic [NODE_W-1:0]     req_node_index;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [NODE_W-1:0]     rsp_granted_node;
   logic [ADDR_W-1:0]     rsp_buffer_address;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted pool state and register copies.
   logic [NODE_W-1:0]    ring_fwd [MAX_NODES];
   logic [NODE_W-1:0]    ring_back [MAX_NODES];
   logic [NODE_W-1:0]    ring_cursor;
   logic [MAX_NODES-1:0] loaned;
   logic [COUNT_W-1:0]   cfg_count;
   logic [BYTES_W-1:0]   cfg_bytes;
   logic [ADDR_W-1:0]    cfg_base;

   pool_result_type expected_grants[$];
   int failures = 0;
   int cycle_count = 0;

   swap_chain_buffer_manager_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_node_index     (req_node_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_node   (rsp_granted_node),
      .rsp_buffer_address (rsp_buffer_address),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Effective ring size after clamping the programmed count.
   function automatic int pool_size();
      if (cfg_count == '0) begin
         return 1;
      end
      if (cfg_count > COUNT_W'(MAX_NODES)) begin
         return MAX_NODES;
      end
      return int'(cfg_count);
   endfunction

   // Rebuild the ring as reset and node count writes do.
   function automatic void rebuild_pool();
      int n;
      n = pool_size();
      for (int i = 0; i < MAX_NODES; i++) begin
         if (i < n) begin
            ring_fwd[i]  = NODE_W'((i + 1) % n);
            ring_back[i] = NODE_W'((i + n - 1) % n);
         end else begin
            ring_fwd[i]  = '0;
            ring_back[i] = '0;
         end
      end
      loaned      = '0;
      ring_cursor = '0;
   endfunction

   function automatic logic [ADDR_W-1:0] buffer_address_of(logic [NODE_W-1:0] idx);
      return cfg_base + ADDR_W'(idx) * ADDR_W'(cfg_bytes);
   endfunction

   // Apply one request to the predicted ring and return the beat it should produce.
   function automatic pool_result_type apply_request(kind_type kind, logic [NODE_W-1:0] idx);
      pool_result_type res;
      logic [NODE_W-1:0] taken;
      logic [NODE_W-1:0] left;
      logic [NODE_W-1:0] right;
      res.status  = STATUS_EMPTY;
      res.node    = '0;
      res.address = '0;
      if (kind == KIND_WRITE_BORROW || kind == KIND_READ_BORROW) begin
         // A borrow fails while the cursor node is the only one linked.
         if (ring_fwd[ring_cursor] != ring_cursor) begin
            taken = (kind == KIND_WRITE_BORROW) ? ring_fwd[ring_cursor] : ring_cursor;
            left  = ring_back[taken];
            right = ring_fwd[taken];
            ring_fwd[left]   = right;
            ring_back[right] = left;
            if (kind == KIND_READ_BORROW) begin
               ring_cursor = right;
            end
            loaned[taken] = 1'b1;
            res.status    = STATUS_GRANTED;
            res.node      = taken;
            res.address   = buffer_address_of(taken);
         end
      end else begin
         // Only nodes inside the ring that are out on loan may come back.
         res.node   = idx;
         res.status = STATUS_REJECTED;
         if (int'(idx) < pool_size() && loaned[idx]) begin
            left  = ring_cursor;
            right = ring_fwd[left];
            ring_fwd[left]   = idx;
            ring_back[idx]   = left;
            ring_fwd[idx]    = right;
            ring_back[right] = idx;
            if (kind == KIND_WRITE_RETURN) begin
               ring_cursor = idx;
            end
            loaned[idx] = 1'b0;
            res.status  = STATUS_RETURNED;
            res.address = buffer_address_of(idx);
         end
      end
      return res;
   endfunction

   // Gap length: mostly none or short, now and then long.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // Random node currently out on loan, or -1 when there is none.
   function automatic int pick_loaned();
      int owned[$];
      for (int i = 0; i < MAX_NODES; i++) begin
         if (loaned[i]) begin
            owned.push_back(i);
         end
      end
      if (owned.size() == 0) begin
         return -1;
      end
      return owned[$urandom_range(0, owned.size() - 1)];
   endfunction

   // Send one request beat and record its prediction once it is taken.
   task automatic issue_request(kind_type kind, logic [NODE_W-1:0] idx);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_node_index <= idx;
      do @(posedge clock); while (req_stall);
      expected_grants.push_back(apply_request(kind, idx));
   endtask

   task automatic pause_requests(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Write one register and mirror it in the predictor.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_NODE_COUNT: begin
            cfg_count = data[COUNT_W-1:0];
            rebuild_pool();
         end
         REG_BUFFER_BYTES: cfg_bytes = data[BYTES_W-1:0];
         REG_BUFFER_BASE:  cfg_base = data;
         default: ;
      endcase
   endtask

   // Stop sending and wait until every pending result is out and the block takes beats again.
   task automatic settle_pool();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      do @(posedge clock); while (req_stall);
      repeat (4) @(posedge clock);
   endtask

   // Reset ring of three nodes: drain it, hit both failure kinds, then refill it.
   task automatic test_reset_ring();
      issue_request(KIND_WRITE_BORROW, 3'd5);
      issue_request(KIND_READ_BORROW, 3'd0);
      issue_request(KIND_WRITE_BORROW, 3'd7);
      issue_request(KIND_READ_BORROW, 3'd2);
      issue_request(KIND_WRITE_RETURN, 3'd7);
      issue_request(KIND_READ_RETURN, 3'd2);
      issue_request(KIND_WRITE_RETURN, 3'd1);
      issue_request(KIND_READ_RETURN, 3'd0);
      issue_request(KIND_READ_RETURN, 3'd0);
   endtask

   // Register extremes, address wrap, clamped counts and buffer writes with nodes on loan.
   task automatic test_register_extremes();
      settle_pool();
      write_register(REG_BUFFER_BYTES, 32'hFFFF_FFFF);
      write_register(REG_BUFFER_BASE, 32'hFFFF_FFFF);
      write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
      write_register(REG_NODE_COUNT, 32'hFFFF_FFF8);
      issue_request(KIND_WRITE_BORROW, 3'd0);
      issue_request(KIND_READ_BORROW, 3'd7);
      issue_request(KIND_WRITE_RETURN, 3'd7);
      pause_requests(3);

      // New buffer spacing only moves the addresses of the nodes coming back.
      settle_pool();
      write_register(REG_BUFFER_BYTES, 32'h0000_1234);
      write_register(REG_BUFFER_BASE, 32'h0000_0000);
      issue_request(KIND_READ_RETURN, 3'd1);
      issue_request(KIND_WRITE_RETURN, 3'd0);

      // A count of zero behaves as a single node, so nothing can be borrowed.
      settle_pool();
      write_register(REG_NODE_COUNT, 32'h0000_0000);
      issue_request(KIND_WRITE_BORROW, 3'd3);
      issue_request(KIND_READ_BORROW, 3'd4);
      issue_request(KIND_READ_RETURN, 3'd0);
      issue_request(KIND_WRITE_RETURN, 3'd0);

      // A count above the maximum behaves as the maximum.
      settle_pool();
      write_register(REG_NODE_COUNT, 32'h0000_000F);
      issue_request(KIND_READ_BORROW, 3'd0);
      issue_request(KIND_READ_RETURN, 3'd0);
   endtask

   // Phases of mostly well-formed borrow and return traffic under random settings.
   task automatic test_random_traffic();
      int pick;
      int victim;
      bit steady;
      kind_type kind;
      logic [NODE_W-1:0] idx;
      logic [COUNT_W-1:0] count;
      logic [BYTES_W-1:0] bytes;
      logic [ADDR_W-1:0] base;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_pool();
         case ($urandom_range(0, 3))
            0: bytes = '0;
            1: bytes = '1;
            default: bytes = BYTES_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: base = '0;
            1: base = '1;
            default: base = $urandom;
         endcase
         write_register(REG_BUFFER_BYTES, ($urandom & 32'hFFFF_0000) | CSR_DATA_W'(bytes));
         write_register(REG_BUFFER_BASE, base);
         if ($urandom_range(0, 4) == 0) begin
            write_register(REG_UNMAPPED, $urandom);
         end

         // Most phases rebuild the ring; the rest keep the loans of the last phase.
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
               count = '0;
            end else if (pick == 1) begin
               count = COUNT_W'(1);
            end else if (pick == 2) begin
               count = COUNT_W'($urandom_range(MAX_NODES + 1, 15));
            end else if (pick == 3) begin
               count = COUNT_W'(MAX_NODES);
            end else begin
               count = COUNT_W'($urandom_range(2, MAX_NODES));
            end
            write_register(REG_NODE_COUNT, ($urandom & 32'hFFFF_FFF0) | CSR_DATA_W'(count));
         end

         steady = ($urandom_range(0, 3) == 0);
         for (int beat = 0; beat < PHASE_BEATS; beat++) begin
            pick   = $urandom_range(0, 99);
            victim = pick_loaned();
            idx    = NODE_W'($urandom_range(0, MAX_NODES - 1));
            if (pick < 12) begin
               kind = kind_type'($urandom_range(0, 3));
            end else if (pick < 55 || victim < 0) begin
               kind = $urandom_range(0, 1) ? KIND_WRITE_BORROW : KIND_READ_BORROW;
            end else begin
               kind = $urandom_range(0, 1) ? KIND_WRITE_RETURN : KIND_READ_RETURN;
               idx  = NODE_W'(victim);
            end
            issue_request(kind, idx);
            if (!steady) begin
               pause_requests(draw_gap());
            end
         end
      end
   endtask

   // Result stall: open stretches of random length, stalls mostly short.
   initial begin : rsp_backpressure
      int open;
      int hold;
      rsp_stall = 1'b0;
      forever begin
         open = $urandom_range(1, 12);
         if ($urandom_range(0, 9) == 0) begin
            open = $urandom_range(40, 120);
         end
         repeat (open) @(negedge clock);
         hold = draw_gap();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every result beat with the oldest prediction.
   always @(posedge clock) begin : check_results
      pool_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grants.size() == 0) begin
            $error("result beat with nothing pending: status %0d node %0d address %h",
                   rsp_status, rsp_granted_node, rsp_buffer_address);
            failures++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_granted_node !== want.node) begin
               $error("granted_node: expected %0d, got %0d", want.node, rsp_granted_node);
               failures++;
            end
            if (rsp_buffer_address !== want.address) begin
               $error("buffer_address: expected %h, got %h", want.address, rsp_buffer_address);
               failures++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_WRITE_BORROW;
      req_node_index = '0;
      csr_we         = 1'b0;
      csr_index      = REG_NODE_COUNT;
      csr_wdata      = '0;
      cfg_count      = NODE_COUNT_RESET;
      cfg_bytes      = '0;
      cfg_base       = '0;
      rebuild_pool();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_reset_ring();
      test_register_extremes();
      test_random_traffic();
      settle_pool();

      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
src/scbm_pkg.sv
src/scbm_ram.sv
src/scbm_seq.sv
src/scbm_out.sv
src/swap_chain_buffer_manager_core.sv
tb/swap_chain_buffer_manager_core_test.sv
